>>> rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg - shared types and constants of the point-in-polygon test
// Vertex record, edge request and result records, orientation codes,
// input kinds, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_W   = 24;
	localparam int RAY_W     = 23;
	localparam int VCOUNT_W  = 8;
	localparam int INDEX_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 23;

	localparam int MIN_VERTICES = 3;
	localparam logic [RAY_W-1:0] RAY_END_RESET = 23'd2560000;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X    = 2'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	// sign class of a cross product
	typedef enum logic [1:0] {
		TURN_ZERO = 2'd0,
		TURN_POS  = 2'd1,
		TURN_NEG  = 2'd2
	} turn_t;

	// one edge handed to the evaluator
	typedef struct packed {
		logic    valid;
		logic    last;
		vertex_t a;
		vertex_t b;
	} edge_req_t;

	// evaluator verdict on one edge plus pipeline status
	typedef struct packed {
		logic valid;
		logic last;
		logic meet;
		logic collinear;
		logic on_edge;
		logic pipe_busy;
	} edge_res_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WALK  = 2'd1,
		ST_DRAIN = 2'd2
	} state_t;

endpackage

>>> rtl/pip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell - one vertex cell of the ring
// Holds one polygon vertex; loads it on a write and passes it to the
// neighbor cell on every rotate cycle.
// ----------------------------------------------------------------------------
module pip_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  pip_pkg::vertex_t shift_in,
	input  logic             wr_en,
	input  pip_pkg::vertex_t wr_data,
	output pip_pkg::vertex_t vtx
);

	pip_pkg::vertex_t vtx_q;

	// load on write, take the neighbor's vertex on rotate
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtx_q <= wr_data;
		end else if (shift_en) begin
			vtx_q <= shift_in;
		end
	end

	assign vtx = vtx_q;

endmodule

>>> rtl/pip_edge_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_eval - pipelined edge versus ray test
// Stage 1 registers the edge, stage 2 holds the cross-product terms,
// ray-side orientations and bounding-box flags; the verdict follows.
// ----------------------------------------------------------------------------
module pip_edge_eval (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_pkg::edge_req_t            req,
	input  pip_pkg::vertex_t              pt,
	input  logic [pip_pkg::RAY_W-1:0]     ray_x,
	output pip_pkg::edge_res_t            res
);

	localparam int EW = pip_pkg::COORD_W + 2;

	function automatic logic signed [EW-1:0] ext(input logic signed [pip_pkg::COORD_W-1:0] v);
		ext = $signed({{2{v[pip_pkg::COORD_W-1]}}, v});
	endfunction

	function automatic logic in_rng(input logic signed [EW-1:0] v,
	                                input logic signed [EW-1:0] e0,
	                                input logic signed [EW-1:0] e1);
		logic signed [EW-1:0] lo;
		logic signed [EW-1:0] hi;
		lo = (e0 < e1) ? e0 : e1;
		hi = (e0 < e1) ? e1 : e0;
		in_rng = (v >= lo) && (v <= hi);
	endfunction

	function automatic pip_pkg::turn_t ray_turn(input logic signed [EW-1:0] run,
	                                            input logic signed [EW-1:0] rise);
		if (run == '0 || rise == '0) begin
			ray_turn = pip_pkg::TURN_ZERO;
		end else if (run[EW-1] != rise[EW-1]) begin
			ray_turn = pip_pkg::TURN_POS;
		end else begin
			ray_turn = pip_pkg::TURN_NEG;
		end
	endfunction

	// stage 1: edge registers
	logic             vld_s1, last_s1;
	pip_pkg::vertex_t a_s1, b_s1;

	// stage 2: products and side flags
	logic                    vld_s2, last_s2;
	logic signed [2*EW-3:0]  m1_s2, m2_s2;
	logic signed [2*EW-2:0]  m3_s2;
	pip_pkg::turn_t          t3_s2, t4_s2;
	logic                    box1_s2, box2_s2, box3_s2, box4_s2;

	logic signed [EW-1:0] ax, ay, bx, by, px, py, fx;
	logic signed [EW-2:0] dy, dx, pxb, pyb;
	logic signed [EW-1:0] fxb, fpx;
	logic signed [2*EW-2:0] v1;
	logic signed [2*EW-1:0] v2;
	pip_pkg::turn_t t1, t2;

	// hold edge valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
		end
	end

	// register incoming edge
	always_ff @(posedge clk) begin
		last_s1 <= req.last;
		a_s1    <= req.a;
		b_s1    <= req.b;
	end

	// form differences
	always_comb begin
		ax  = ext(a_s1.x);
		ay  = ext(a_s1.y);
		bx  = ext(b_s1.x);
		by  = ext(b_s1.y);
		px  = ext(pt.x);
		py  = ext(pt.y);
		fx  = $signed({3'b000, ray_x});
		dy  = (EW-1)'(by - ay);
		dx  = (EW-1)'(bx - ax);
		pxb = (EW-1)'(px - bx);
		pyb = (EW-1)'(py - by);
		fxb = fx - bx;
		fpx = fx - px;
	end

	// multiply and capture side flags
	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		m1_s2   <= dy * pxb;
		m2_s2   <= dx * pyb;
		m3_s2   <= dy * fxb;
		t3_s2   <= ray_turn(fpx, ay - py);
		t4_s2   <= ray_turn(fpx, by - py);
		box1_s2 <= in_rng(px, ax, bx) && in_rng(py, ay, by);
		box2_s2 <= in_rng(fx, ax, bx) && in_rng(py, ay, by);
		box3_s2 <= in_rng(ax, px, fx) && (ay == py);
		box4_s2 <= in_rng(bx, px, fx) && (by == py);
	end

	// finish cross products and decide the edge
	always_comb begin
		v1 = (2*EW-1)'(m1_s2) - (2*EW-1)'(m2_s2);
		v2 = (2*EW)'(m3_s2) - (2*EW)'(m2_s2);
		t1 = (v1 == '0) ? pip_pkg::TURN_ZERO :
		     (v1[2*EW-2] ? pip_pkg::TURN_NEG : pip_pkg::TURN_POS);
		t2 = (v2 == '0) ? pip_pkg::TURN_ZERO :
		     (v2[2*EW-1] ? pip_pkg::TURN_NEG : pip_pkg::TURN_POS);
		res.valid     = vld_s2;
		res.last      = last_s2;
		res.meet      = ((t1 != t2) && (t3_s2 != t4_s2)) ||
		                ((t1 == pip_pkg::TURN_ZERO) && box1_s2) ||
		                ((t2 == pip_pkg::TURN_ZERO) && box2_s2) ||
		                ((t3_s2 == pip_pkg::TURN_ZERO) && box3_s2) ||
		                ((t4_s2 == pip_pkg::TURN_ZERO) && box4_s2);
		res.collinear = res.meet && (t1 == pip_pkg::TURN_ZERO);
		res.on_edge   = box1_s2;
		res.pipe_busy = vld_s1 || vld_s2;
	end

endmodule

>>> rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test - ray casting point-in-polygon test
// Polygon vertices live in a ring of cells; a query rotates the ring once
// past a pipelined edge evaluator and counts ray crossings.
// ----------------------------------------------------------------------------
// Usage:
//   Items are transferred on start while busy is low. kind 0 loads vertex
//   vertex_index (slots at or above MAX_VERTICES are dropped) and gives no
//   result. kind 1 queries point (coord_x, coord_y).
//   Each query gives one result: done is high for exactly one cycle with
//   inside_res and edge_rule_decided; the receiver cannot stall it.
//   Timing: with fewer than three vertices the result follows in the next
//   cycle after the transfer and busy stays low. Otherwise the ring rotates
//   once, one edge per cycle through the pipelined evaluator, and the
//   result is registered once the last edge has passed the evaluator's
//   stages; busy stays high through the rotation and until the evaluator
//   has drained. A collinear edge settles the result early.
//   Configuration: cfg_valid/cfg_ready (always ready) write vertex_count
//   (index 0) and ray_end_x (index 1); the user must write them only while
//   the block is idle, as the block itself does not enforce it.
//   Reset clears control state, vertex_count to 0 and ray_end_x to 10000.0;
//   vertex cells stay undefined until written.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [pip_pkg::INDEX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_y,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pip_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pip_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 done,
	output logic                                 inside_res,
	output logic                                 edge_rule_decided
);

	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int CNTW = (CW > pip_pkg::VCOUNT_W) ? CW : pip_pkg::VCOUNT_W;
	localparam logic [CW-1:0] LAST_STEP = CW'(MAX_VERTICES - 1);

	pip_pkg::state_t state_q, state_d;

	logic [pip_pkg::VCOUNT_W-1:0] vertex_count_q;
	logic [pip_pkg::RAY_W-1:0]    ray_end_x_q;
	logic [CW-1:0]                step_q, n_q;
	pip_pkg::vertex_t             pt_q, v0_q, wr_vtx;
	logic                         hits_q, sent_q;
	logic                         done_q, inside_q, decided_q;

	logic            accept, wr_go, query_go, short_go, rotate, emit;
	logic [CNTW-1:0] vc_ext, n_full;
	logic [CW-1:0]   n_sat;

	pip_pkg::vertex_t   vtx [MAX_VERTICES];
	pip_pkg::edge_req_t req;
	pip_pkg::edge_res_t ev;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != pip_pkg::ST_IDLE);
	assign accept    = start && !busy;

	// saturate the vertex count to the ring size
	always_comb begin
		vc_ext   = CNTW'(vertex_count_q);
		n_full   = (vc_ext > CNTW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : vc_ext;
		n_sat    = CW'(n_full);
		wr_go    = accept && (kind == pip_pkg::KIND_WRITE);
		query_go = accept && (kind == pip_pkg::KIND_QUERY) &&
		           (n_full >= CNTW'(pip_pkg::MIN_VERTICES));
		short_go = accept && (kind == pip_pkg::KIND_QUERY) &&
		           (n_full < CNTW'(pip_pkg::MIN_VERTICES));
		wr_vtx.x = coord_x;
		wr_vtx.y = coord_y;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			ray_end_x_q    <= pip_pkg::RAY_END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pip_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data[pip_pkg::VCOUNT_W-1:0];
				pip_pkg::REG_RAY_END_X:    ray_end_x_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// vertex ring: each cell passes its vertex to the previous one on rotate
	for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_ring
		localparam int NXT = (j + 1) % MAX_VERTICES;
		pip_cell u_cell (
			.clk      (clk),
			.shift_en (rotate),
			.shift_in (vtx[NXT]),
			.wr_en    (wr_go && (32'(vertex_index) == j)),
			.wr_data  (wr_vtx),
			.vtx      (vtx[j])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and rotate control
	always_comb begin
		state_d = state_q;
		rotate  = 1'b0;
		unique case (state_q)
			pip_pkg::ST_IDLE: begin
				if (query_go) state_d = pip_pkg::ST_WALK;
			end
			pip_pkg::ST_WALK: begin
				rotate = 1'b1;
				if (step_q == LAST_STEP) state_d = pip_pkg::ST_DRAIN;
			end
			pip_pkg::ST_DRAIN: begin
				if (!ev.pipe_busy) state_d = pip_pkg::ST_IDLE;
			end
			default: state_d = pip_pkg::ST_IDLE;
		endcase
	end

	// step counter over one full ring rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (rotate) begin
			step_q <= step_q + CW'(1);
		end else begin
			step_q <= '0;
		end
	end

	// latch query point, edge count and first vertex
	always_ff @(posedge clk) begin
		if (query_go) begin
			pt_q.x <= coord_x;
			pt_q.y <= coord_y;
			n_q    <= n_sat;
			v0_q   <= vtx[0];
		end
	end

	// issue the edge at the ring head, closing back to vertex 0
	always_comb begin
		req.valid = (state_q == pip_pkg::ST_WALK) && (step_q < n_q);
		req.last  = (step_q == n_q - CW'(1));
		req.a     = vtx[0];
		req.b     = req.last ? v0_q : vtx[1];
	end

	pip_edge_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pt     (pt_q),
		.ray_x  (ray_end_x_q),
		.res    (ev)
	);

	assign emit = ev.valid && !sent_q && (ev.collinear || ev.last);

	// accumulate crossing parity and drop edges after the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= 1'b0;
			sent_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= short_go || emit;
			if (query_go) begin
				hits_q <= 1'b0;
				sent_q <= 1'b0;
			end else if (ev.valid && !sent_q) begin
				hits_q <= hits_q ^ ev.meet;
				if (emit) sent_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (short_go) begin
			inside_q  <= 1'b0;
			decided_q <= 1'b0;
		end else if (emit) begin
			inside_q  <= ev.collinear ? ev.on_edge : (hits_q ^ ev.meet);
			decided_q <= ev.collinear;
		end
	end

	assign done              = done_q;
	assign inside_res        = inside_q;
	assign edge_rule_decided = decided_q;

	// a degenerate polygon answers outside on the next cycle
	a_short_query: assert property (@(posedge clk) disable iff (!arst_n)
		short_go |=> (done && !inside_res && !edge_rule_decided))
		else $error("short query did not answer outside");

	// the evaluator is empty whenever the controller is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_IDLE) |-> !ev.pipe_busy)
		else $error("edge evaluator busy while idle");

	// every walk has delivered its result before going idle
	a_result_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_DRAIN && !ev.pipe_busy) |-> sent_q)
		else $error("walk ended without a result");

	// no result while the evaluator holds nothing and no short query ran
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!short_go && !ev.valid) |=> !done)
		else $error("result strobe without a cause");

endmodule

>>> tb/point_in_polygon_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb - self-checking bench for the ray casting test
// Loads polygons into the vertex store and fires query points at them. Points
// sit on vertices, on edges, on edge extensions, level with vertices and at the
// coordinate extremes. A scoreboard walks the edges up to the first collinear one with exact
// orientation signs to predict each verdict and compares it against the done strobe.
// ----------------------------------------------------------------------------
import pip_pkg::*;

class pip_scoreboard;
	typedef struct {
		longint x;
		longint y;
	} xy_t;

	typedef struct packed {
		bit in_poly;
		bit by_edge;
	} verdict_t;

	vertex_t             polygon [128];
	logic [VCOUNT_W-1:0] vertex_count;
	logic [RAY_W-1:0]    ray_end_x;
	int unsigned         slot_limit;
	verdict_t            verdict_q [$];
	int                  mismatches;
	int                  vertex_writes;
	int                  queries;
	int                  edge_settled;
	int                  inside_seen;

	function new(int unsigned max_slots);
		slot_limit    = max_slots;
		vertex_count  = '0;
		ray_end_x     = RAY_END_RESET;
		mismatches    = 0;
		vertex_writes = 0;
		queries       = 0;
		edge_settled  = 0;
		inside_seen   = 0;
		foreach (polygon[i])
			polygon[i] = '0;
	endfunction

	function int pending();
		return verdict_q.size();
	endfunction

	// mirror a register transfer; spare indexes do nothing
	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_VERTEX_COUNT: vertex_count = data[VCOUNT_W-1:0];
			REG_RAY_END_X:    ray_end_x = data[RAY_W-1:0];
			default: ;
		endcase
	endfunction

	// sign class of the cross product for the turn a -> b -> c
	function turn_t orient(xy_t a, xy_t b, xy_t c);
		longint v;
		v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
		if (v == 0)
			return TURN_ZERO;
		return (v > 0) ? TURN_POS : TURN_NEG;
	endfunction

	// b lies in the bounding box spanned by a and c
	function bit in_box(xy_t a, xy_t b, xy_t c);
		return b.x <= ((a.x > c.x) ? a.x : c.x) && b.x >= ((a.x < c.x) ? a.x : c.x) &&
		       b.y <= ((a.y > c.y) ? a.y : c.y) && b.y >= ((a.y < c.y) ? a.y : c.y);
	endfunction

	function bit crosses(xy_t a1, xy_t b1, xy_t a2, xy_t b2);
		turn_t t1, t2, t3, t4;
		t1 = orient(a1, b1, a2);
		t2 = orient(a1, b1, b2);
		t3 = orient(a2, b2, a1);
		t4 = orient(a2, b2, b1);
		if (t1 != t2 && t3 != t4)
			return 1'b1;
		// collinear touches
		if (t1 == TURN_ZERO && in_box(a1, a2, b1))
			return 1'b1;
		if (t2 == TURN_ZERO && in_box(a1, b2, b1))
			return 1'b1;
		if (t3 == TURN_ZERO && in_box(a2, a1, b2))
			return 1'b1;
		if (t4 == TURN_ZERO && in_box(a2, b1, b2))
			return 1'b1;
		return 1'b0;
	endfunction

	function xy_t corner(int unsigned i);
		xy_t r;
		r.x = signed'(polygon[i].x);
		r.y = signed'(polygon[i].y);
		return r;
	endfunction

	// store a vertex, or walk the polygon edges and queue the verdict
	function void note_item(logic k, logic [INDEX_W-1:0] idx,
		logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
		verdict_t    v;
		xy_t         p, far_end, a, b;
		int unsigned n, nxt, hits;
		bit          settled;
		if (k == KIND_WRITE) begin
			polygon[idx].x = px;
			polygon[idx].y = py;
			vertex_writes++;
			return;
		end
		queries++;
		v = '0;
		n = (vertex_count > slot_limit) ? slot_limit : vertex_count;
		if (n >= MIN_VERTICES) begin
			p.x       = px;
			p.y       = py;
			far_end.x = ray_end_x;
			far_end.y = py;
			hits      = 0;
			settled   = 1'b0;
			for (int unsigned i = 0; i < n && !settled; i++) begin
				nxt = (i + 1 == n) ? 0 : i + 1;
				a   = corner(i);
				b   = corner(nxt);
				if (crosses(a, b, p, far_end)) begin
					// a collinear edge decides on its own
					if (orient(a, p, b) == TURN_ZERO) begin
						v.in_poly = in_box(a, p, b);
						v.by_edge = 1'b1;
						settled   = 1'b1;
					end else begin
						hits++;
					end
				end
			end
			if (!settled)
				v.in_poly = hits[0];
		end
		if (v.by_edge)
			edge_settled++;
		verdict_q.push_back(v);
	endfunction

	// compare one result against the oldest queued verdict
	function void check_result(logic in_poly, logic by_edge);
		verdict_t v;
		if (verdict_q.size() == 0) begin
			$error("result with no query waiting: inside_res=%0b edge_rule_decided=%0b",
				in_poly, by_edge);
			mismatches++;
			return;
		end
		v = verdict_q.pop_front();
		if (in_poly === 1'b1)
			inside_seen++;
		if (in_poly !== v.in_poly) begin
			$error("inside_res: expected %0b, got %0b", v.in_poly, in_poly);
			mismatches++;
		end
		if (by_edge !== v.by_edge) begin
			$error("edge_rule_decided: expected %0b, got %0b", v.by_edge, by_edge);
			mismatches++;
		end
	endfunction
endclass

module point_in_polygon_test_tb;

	localparam int MAX_VERTS     = 128;
	localparam int SETTLE_CYCLES = MAX_VERTS + 8;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int ITEM_TARGET   = 1350;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] SIDE      = 24'sd2560;
	localparam logic signed [COORD_W-1:0] HALF      = 24'sd1280;

	typedef enum int {
		SHAPE_GRID,
		SHAPE_WIDE
	} shape_style_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic                        kind;
	logic [INDEX_W-1:0]          vertex_index;
	logic signed [COORD_W-1:0]   coord_x;
	logic signed [COORD_W-1:0]   coord_y;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        done;
	logic                        inside_res;
	logic                        edge_rule_decided;

	pip_scoreboard               sb;
	logic signed [COORD_W-1:0]   shape_x [MAX_VERTS];
	logic signed [COORD_W-1:0]   shape_y [MAX_VERTS];
	int                          shape_n;
	shape_style_t                style;
	int                          step;
	int                          idle_pct;
	int                          items_sent;
	int                          reg_writes;
	int                          phase;
	int                          cycle_count;

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VERTS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.vertex_index     (vertex_index),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.inside_res       (inside_res),
		.edge_rule_decided(edge_rule_decided)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// check every result strobe
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(inside_res, edge_rule_decided);
	end

	// present one item and hold it until the transfer
	task automatic send_item(input logic k, input logic [INDEX_W-1:0] idx,
		input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py);
		@(negedge clk);
		start        <= 1'b1;
		kind         <= k;
		vertex_index <= idx;
		coord_x      <= px;
		coord_y      <= py;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(k, idx, px, py);
		if (k == KIND_WRITE) begin
			shape_x[idx] = px;
			shape_y[idx] = py;
		end
		items_sent++;
	endtask

	task automatic idle_gap();
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every query has answered
	task automatic wait_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// drain, then let a full ring rotation finish before touching registers
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		if (style == SHAPE_GRID)
			return COORD_W'((int'($urandom_range(0, 12)) - 6) * step);
		case ($urandom_range(0, 9))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			default: return COORD_W'($urandom());
		endcase
	endfunction

	// aim query points at vertices, edges, edge lines, vertex levels, the y extremes and random spots
	function automatic void pick_point(output logic signed [COORD_W-1:0] px,
		output logic signed [COORD_W-1:0] py);
		int j, k;
		j = (shape_n > 0) ? $urandom_range(0, shape_n - 1) : 0;
		k = (j + 1 >= shape_n) ? 0 : j + 1;
		case ($urandom_range(0, 9))
			0, 1: begin
				px = shape_x[j];
				py = shape_y[j];
			end
			2, 3: begin
				px = COORD_W'((longint'(shape_x[j]) + longint'(shape_x[k])) >>> 1);
				py = COORD_W'((longint'(shape_y[j]) + longint'(shape_y[k])) >>> 1);
			end
			4: begin
				px = COORD_W'(2 * longint'(shape_x[k]) - longint'(shape_x[j]));
				py = COORD_W'(2 * longint'(shape_y[k]) - longint'(shape_y[j]));
			end
			5: begin
				px = rand_coord();
				py = shape_y[j];
			end
			6: begin
				px = COORD_W'($urandom());
				py = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
			end
			default: begin
				px = COORD_W'(int'(rand_coord()) + int'($urandom_range(0, 2)) - 1);
				py = COORD_W'(int'(rand_coord()) + int'($urandom_range(0, 2)) - 1);
			end
		endcase
	endfunction

	initial begin
		logic signed [COORD_W-1:0] qx, qy;
		logic [CFG_DATA_W-1:0]     count_word;
		logic [RAY_W-1:0]          ray;
		int                        n, m, q, r;

		sb           = new(MAX_VERTS);
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = KIND_WRITE;
		vertex_index = '0;
		coord_x      = '0;
		coord_y      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_VERTEX_COUNT;
		cfg_data     = '0;
		idle_pct     = 0;
		items_sent   = 0;
		reg_writes   = 0;
		phase        = 0;
		shape_n      = 0;
		style        = SHAPE_GRID;
		step         = 1;
		foreach (shape_x[i]) begin
			shape_x[i] = '0;
			shape_y[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// spare register indexes must not disturb anything
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, 23'h2AAAAA);

		// empty polygon at the coordinate extremes
		send_item(KIND_QUERY, 7'd127, COORD_MIN, COORD_MAX);
		send_item(KIND_QUERY, 7'd0, COORD_MAX, COORD_MIN);
		send_item(KIND_WRITE, 7'd127, COORD_MAX, COORD_MIN);
		send_item(KIND_WRITE, 7'd126, COORD_MIN, COORD_MAX);

		// load a square of side ten
		send_item(KIND_WRITE, 7'd0, 24'sd0, 24'sd0);
		send_item(KIND_WRITE, 7'd1, SIDE, 24'sd0);
		send_item(KIND_WRITE, 7'd2, SIDE, SIDE);
		send_item(KIND_WRITE, 7'd3, 24'sd0, SIDE);

		// two vertices are too few
		settle();
		write_reg(REG_VERTEX_COUNT, 23'd2);
		send_item(KIND_QUERY, 7'd5, HALF, HALF);

		// center, outside, on an edge, on a vertex, on an edge line, on the bottom edge, level with and above the top
		settle();
		write_reg(REG_VERTEX_COUNT, 23'd4);
		send_item(KIND_QUERY, 7'd0, HALF, HALF);
		send_item(KIND_QUERY, 7'd0, 24'sd5000, HALF);
		send_item(KIND_QUERY, 7'd0, SIDE, HALF);
		send_item(KIND_QUERY, 7'd0, 24'sd0, 24'sd0);
		send_item(KIND_QUERY, 7'd0, -HALF, 24'sd0);
		send_item(KIND_QUERY, 7'd0, HALF, 24'sd0);
		send_item(KIND_QUERY, 7'd0, -24'sd100, SIDE);
		send_item(KIND_QUERY, 7'd0, HALF, SIDE + 24'sd1);

		// ray end behind the point runs the ray to the left
		settle();
		write_reg(REG_RAY_END_X, '0);
		send_item(KIND_QUERY, 7'd0, HALF, HALF);
		send_item(KIND_QUERY, 7'd0, 24'sd5000, HALF);
		send_item(KIND_QUERY, 7'd0, -24'sd5, HALF);

		// farthest ray end, and a ray that collapses to the point
		settle();
		write_reg(REG_RAY_END_X, '1);
		send_item(KIND_QUERY, 7'd0, HALF, HALF);
		send_item(KIND_QUERY, 7'd0, COORD_MAX, HALF);

		// random polygons, each loaded and then queried
		while (items_sent < ITEM_TARGET) begin
			settle();
			// idling plan: none, sender 73 %, none (results cannot stall), sender 36 %
			case (phase % 4)
				1:       idle_pct = 73;
				3:       idle_pct = 36;
				default: idle_pct = 0;
			endcase
			phase++;

			// mostly small polygons, a few full or oversized counts
			r = $urandom_range(0, 99);
			if (r < 6)
				n = $urandom_range(0, 2);
			else if (r < 80)
				n = $urandom_range(3, 10);
			else if (r < 92)
				n = $urandom_range(11, 40);
			else if (r < 96)
				n = $urandom_range(100, 128);
			else
				n = $urandom_range(129, 255);
			m = (n > MAX_VERTS) ? MAX_VERTS : n;

			style = ($urandom_range(0, 4) == 0) ? SHAPE_WIDE : SHAPE_GRID;
			case ($urandom_range(0, 2))
				0:       step = 1;
				1:       step = 256;
				default: step = $urandom_range(2, 60000);
			endcase
			case ($urandom_range(0, 5))
				0:       ray = '0;
				1:       ray = '1;
				2:       ray = RAY_END_RESET;
				3:       ray = RAY_W'($urandom_range(0, 6 * step));
				default: ray = RAY_W'($urandom());
			endcase

			// program count and ray end in either order, upper count bits sometimes set
			count_word = CFG_DATA_W'(n);
			if ($urandom_range(0, 1))
				count_word[CFG_DATA_W-1:VCOUNT_W] = (CFG_DATA_W - VCOUNT_W)'($urandom());
			if ($urandom_range(0, 1)) begin
				write_reg(REG_VERTEX_COUNT, count_word);
				write_reg(REG_RAY_END_X, ray);
			end else begin
				write_reg(REG_RAY_END_X, ray);
				write_reg(REG_VERTEX_COUNT, count_word);
			end
			if ($urandom_range(0, 6) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_DATA_W'($urandom()));

			// load every slot the walk will read
			shape_n = m;
			for (int i = 0; i < m; i++) begin
				send_item(KIND_WRITE, INDEX_W'(i), rand_coord(), rand_coord());
				idle_gap();
			end

			// queries with stray vertex rewrites mixed in
			q = (m > 40) ? $urandom_range(3, 8) : $urandom_range(8, 30);
			for (int j = 0; j < q; j++) begin
				if ($urandom_range(0, 99) < 15) begin
					send_item(KIND_WRITE, INDEX_W'($urandom()), rand_coord(), rand_coord());
				end else begin
					pick_point(qx, qy);
					send_item(KIND_QUERY, INDEX_W'($urandom()), qx, qy);
				end
				idle_gap();
				if ($urandom_range(0, 99) < 6)
					wait_results();
			end
		end

		settle();
		$display("Covered %0d vertex loads and %0d point queries (%0d settled on an edge, %0d inside)",
			sb.vertex_writes, sb.queries, sb.edge_settled, sb.inside_seen);
		$display("across %0d register writes in %0d random polygons, %0d cycles",
			reg_writes, phase, cycle_count);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> point_in_polygon_test.f
rtl/pip_pkg.sv
rtl/pip_cell.sv
rtl/pip_edge_eval.sv
rtl/point_in_polygon_test.sv
tb/point_in_polygon_test_tb.sv
